// ===== rtl/gha_pkg.sv =====
// Shared constants and types for the generational handle allocator.
package gha_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int GEN_BITS_DEF   = 8;
  localparam int HANDLE_W       = 20;
  localparam int STATUS_W       = 2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

  localparam logic ACT_CREATE  = 1'b0;
  localparam logic ACT_DESTROY = 1'b1;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
  localparam logic [OP_W-1:0] OP_FULL    = 3'd3;
  localparam logic [OP_W-1:0] OP_FRESH   = 3'd4;
  localparam logic [OP_W-1:0] OP_EMIT    = 3'd5;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_destroy;
    logic stack_empty;
    logic at_limit;
  } stat_t;

endpackage

// ===== rtl/gha_ctrl.sv =====
// Sequencing state machine for the generational handle allocator.
module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gha_pkg::stat_t stat,
  output gha_pkg::cmd_t  cmd,
  output logic          busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = gha_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
        if (stat.is_destroy) begin
          cmd.op = gha_pkg::OP_DESTROY;
        end else if (!stat.stack_empty) begin
          cmd.op     = gha_pkg::OP_POP;
          state_next = S_GEN;
        end else if (stat.at_limit) begin
          cmd.op = gha_pkg::OP_FULL;
        end else begin
          cmd.op = gha_pkg::OP_FRESH;
        end
      end
      S_GEN: begin
        cmd.op     = gha_pkg::OP_EMIT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/gha_dp.sv =====
// Datapath of the generational handle allocator: memories, counters and result registers.
module gha_dp #(
  parameter int INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          action,
  input  logic [gha_pkg::HANDLE_W-1:0]  handle_in,
  input  gha_pkg::cmd_t                 cmd,
  output gha_pkg::stat_t                stat,
  output logic                          done,
  output logic [gha_pkg::HANDLE_W-1:0]  handle_out,
  output logic [gha_pkg::STATUS_W-1:0]  status
);

  localparam int SLOTS = 1 << INDEX_BITS;
  localparam int EXT_W = INDEX_BITS + GEN_BITS + gha_pkg::HANDLE_W;
  localparam logic [INDEX_BITS-1:0] FRESH_LIMIT = {INDEX_BITS{1'b1}};

  logic [GEN_BITS-1:0]   gen_mem [SLOTS];
  logic [INDEX_BITS-1:0] stk_mem [SLOTS];

  logic [GEN_BITS-1:0]   gen_rd;
  logic [INDEX_BITS-1:0] stk_rd;
  logic                  act_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [GEN_BITS-1:0]   hgen_q;
  logic [INDEX_BITS-1:0] slot_q;
  logic [INDEX_BITS:0]   free_depth;
  logic [INDEX_BITS-1:0] next_fresh;

  logic [EXT_W-1:0]      h_ext;
  logic [INDEX_BITS-1:0] in_idx;
  logic [GEN_BITS-1:0]   in_gen;
  logic [INDEX_BITS:0]   depth_m1;
  logic [INDEX_BITS-1:0] gen_raddr;
  logic                  live;
  logic                  destroy_ok;
  logic                  push_ok;
  logic                  gen_we;
  logic [INDEX_BITS-1:0] gen_waddr;
  logic [GEN_BITS-1:0]   gen_wdata;
  logic                  finish;

  assign h_ext     = EXT_W'(handle_in);
  assign in_idx    = handle_in[INDEX_BITS-1:0];
  assign in_gen    = GEN_BITS'(h_ext >> INDEX_BITS);
  assign depth_m1  = free_depth - 1'b1;
  assign gen_raddr = (cmd.op == gha_pkg::OP_POP) ? stk_rd : in_idx;

  // A handle is live when its index has been issued and its generation is current.
  assign live = (idx_q != '0) && (idx_q < next_fresh) && (hgen_q == gen_rd);

  assign destroy_ok = (cmd.op == gha_pkg::OP_DESTROY) && live;
  assign push_ok    = destroy_ok && !free_depth[INDEX_BITS];
  assign gen_we     = destroy_ok || (cmd.op == gha_pkg::OP_FRESH);
  assign gen_waddr  = (cmd.op == gha_pkg::OP_FRESH) ? next_fresh : idx_q;
  assign gen_wdata  = (cmd.op == gha_pkg::OP_FRESH) ? '0 : gen_rd + 1'b1;

  assign finish = (cmd.op == gha_pkg::OP_DESTROY) || (cmd.op == gha_pkg::OP_FULL) ||
                  (cmd.op == gha_pkg::OP_FRESH) || (cmd.op == gha_pkg::OP_EMIT);

  assign stat.is_destroy  = (act_q == gha_pkg::ACT_DESTROY);
  assign stat.stack_empty = (free_depth == '0);
  assign stat.at_limit    = (next_fresh == FRESH_LIMIT);

  // Generation memory: each index is written when it is first issued; reads of unissued entries go unused.
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (cmd.load || (cmd.op == gha_pkg::OP_POP)) begin
      gen_rd <= gen_mem[gen_raddr];
    end
  end

  // Free stack memory.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stk_mem[free_depth[INDEX_BITS-1:0]] <= idx_q;
    end
    if (cmd.load) begin
      stk_rd <= stk_mem[depth_m1[INDEX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      next_fresh <= INDEX_BITS'(1);
      done       <= 1'b0;
    end else begin
      done <= finish;
      if (cmd.op == gha_pkg::OP_POP) begin
        free_depth <= depth_m1;
      end else if (push_ok) begin
        free_depth <= free_depth + 1'b1;
      end
      if (cmd.op == gha_pkg::OP_FRESH) begin
        next_fresh <= next_fresh + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      idx_q  <= in_idx;
      hgen_q <= in_gen;
    end
    if (cmd.op == gha_pkg::OP_POP) begin
      slot_q <= stk_rd;
    end
    case (cmd.op)
      gha_pkg::OP_DESTROY: begin
        handle_out <= '0;
        status     <= live ? gha_pkg::ST_OK : gha_pkg::ST_DEAD;
      end
      gha_pkg::OP_FULL: begin
        handle_out <= '0;
        status     <= gha_pkg::ST_FULL;
      end
      gha_pkg::OP_FRESH: begin
        handle_out <= gha_pkg::HANDLE_W'(next_fresh);
        status     <= gha_pkg::ST_OK;
      end
      gha_pkg::OP_EMIT: begin
        handle_out <= gha_pkg::HANDLE_W'({gen_rd, slot_q});
        status     <= gha_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/generational_handle_allocator_core.sv =====
// Top level of the generational handle allocator.
//
// A command is a transfer on the input side: it is taken at a rising edge where
// start is high and busy is low. action selects create (0) or destroy (1) of
// handle_in. Each command produces exactly one result, shown on handle_out and
// status for a single cycle while done is high; the receiver must take it then.
//
// A destroy, a create of a fresh index and a create that fails for lack of
// indexes go from the read state straight back to idle. A create that reuses
// a freed index also passes the generation state, since the index must come
// out of the free stack memory before its generation can be read from the
// generation memory, each through its single registered read port. busy drops
// in the cycle that done is shown, so the next command may be transferred then.
//
// Reset (rst, synchronous) empties the free stack and restarts fresh indexes
// at 1. The generation memory needs no clearing pass: each fresh index has
// its generation zeroed when it is first issued, and reads of other entries
// go unused. The block is ready in the cycle after reset is released.
module generational_handle_allocator_core #(
  parameter int INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [gha_pkg::HANDLE_W-1:0]  handle_in,
  output logic                          done,
  output logic [gha_pkg::HANDLE_W-1:0]  handle_out,
  output logic [gha_pkg::STATUS_W-1:0]  status
);

  gha_pkg::cmd_t  cmd;
  gha_pkg::stat_t stat;

  // The controller sequences reads, decisions and write-back.
  gha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath owns both memories, the stack depth, the fresh counter and
  // the result registers.
  gha_dp #(
    .INDEX_BITS (INDEX_BITS),
    .GEN_BITS   (GEN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .handle_in  (handle_in),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .handle_out (handle_out),
    .status     (status)
  );

endmodule

// ===== rtl/gha_checker.sv =====
// Port-level checks for the generational handle allocator, bound to the top level.
module gha_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [gha_pkg::HANDLE_W-1:0]  handle_out,
  input logic [gha_pkg::STATUS_W-1:0]  status
);

  // No result can appear in the cycle right after a transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too early after transfer");

  // Work ends exactly when its result is shown.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result without preceding work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == gha_pkg::ST_OK || status == gha_pkg::ST_FULL ||
              status == gha_pkg::ST_DEAD))
    else $error("unknown status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != gha_pkg::ST_OK) |-> (handle_out == '0))
    else $error("failed command returned a handle");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .handle_out (handle_out),
  .status     (status)
);

// ===== tb/generational_handle_allocator_core_tb.sv =====
// Self-checking testbench for the generational handle allocator core.
`timescale 1ns / 100ps

typedef struct packed {
  logic [gha_pkg::HANDLE_W-1:0] handle;
  logic [gha_pkg::STATUS_W-1:0] status;
} alloc_result_t;

// Keeps a private copy of the allocator state and the results still owed by the block.
class allocator_ledger;
  localparam int IDX_W = gha_pkg::INDEX_BITS_DEF;
  localparam int GEN_W = gha_pkg::GEN_BITS_DEF;
  localparam int SLOTS = 1 << IDX_W;

  bit [GEN_W-1:0] gen_of [SLOTS];
  bit [IDX_W-1:0] freed [SLOTS];
  bit [IDX_W:0]   freed_depth;
  bit [IDX_W-1:0] next_fresh;
  alloc_result_t  due_results [$];
  int             fail_count;

  function new();
    freed_depth = '0;
    next_fresh  = IDX_W'(1);
    fail_count  = 0;
  endfunction

  // Applies one accepted command to the state and queues the result it must produce.
  function alloc_result_t note_command(logic act, logic [gha_pkg::HANDLE_W-1:0] h);
    alloc_result_t  r;
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] g;
    r.handle = '0;
    r.status = gha_pkg::ST_OK;
    if (act == gha_pkg::ACT_CREATE) begin
      if (freed_depth != 0) begin
        freed_depth = freed_depth - 1'b1;
        slot = freed[freed_depth[IDX_W-1:0]];
        r.handle = {gen_of[slot], slot};
      end else if (next_fresh >= SLOTS - 1) begin
        r.status = gha_pkg::ST_FULL;
      end else begin
        r.handle = {gen_of[next_fresh], next_fresh};
        next_fresh = next_fresh + 1'b1;
      end
    end else begin
      slot = h[IDX_W-1:0];
      g    = h[IDX_W +: GEN_W];
      if (slot == 0 || slot >= next_fresh || g != gen_of[slot]) begin
        r.status = gha_pkg::ST_DEAD;
      end else begin
        gen_of[slot] = gen_of[slot] + 1'b1;
        // A full stack drops the push, but the generation still moves on.
        if (freed_depth < SLOTS) begin
          freed[freed_depth[IDX_W-1:0]] = slot;
          freed_depth = freed_depth + 1'b1;
        end
      end
    end
    due_results.push_back(r);
    return r;
  endfunction

  task report_mismatch(string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task check_result(logic [gha_pkg::HANDLE_W-1:0] hout, logic [gha_pkg::STATUS_W-1:0] st);
    alloc_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result handle %h status %0d", hout, st));
    end else begin
      want = due_results.pop_front();
      if (hout !== want.handle)
        report_mismatch($sformatf("handle_out %h, expected %h", hout, want.handle));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
    end
  endtask
endclass

module generational_handle_allocator_core_tb;

  localparam int IDX_W = gha_pkg::INDEX_BITS_DEF;
  localparam int GEN_W = gha_pkg::GEN_BITS_DEF;
  localparam int SLOTS = 1 << IDX_W;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         action;
  logic [gha_pkg::HANDLE_W-1:0] handle_in;
  logic                         done;
  logic [gha_pkg::HANDLE_W-1:0] handle_out;
  logic [gha_pkg::STATUS_W-1:0] status;

  allocator_ledger     ledger;
  alloc_result_t       last_result;
  // Handles the stimulus believes to be live, and recently destroyed ones kept for replay.
  logic [gha_pkg::HANDLE_W-1:0] live_handles [$];
  logic [gha_pkg::HANDLE_W-1:0] stale_handles [$];
  // While nonzero, the sender issues back to back with no idle cycles.
  int                  calm_left;

  generational_handle_allocator_core #(
    .INDEX_BITS(IDX_W),
    .GEN_BITS  (GEN_W)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .handle_in (handle_in),
    .done      (done),
    .handle_out(handle_out),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run. The slowest correct run stays under a quarter of a
  // millisecond of simulated time even with the longest gaps on every transfer.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Every result is valid for exactly one cycle and cannot be held off, so it
  // is checked at the rising edge that closes the cycle in which done is high.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1)
        ledger.check_result(handle_out, status);
      else if (done !== 1'b0)
        ledger.report_mismatch("done is unknown");
    end
  end

  function automatic logic [gha_pkg::HANDLE_W-1:0] pack_handle(int gen, int idx);
    logic [GEN_W-1:0] g;
    logic [IDX_W-1:0] i;
    g = GEN_W'(gen);
    i = IDX_W'(idx);
    return {g, i};
  endfunction

  // Idle cycles before the next transfer: mostly a random gap, with occasional
  // stretches of back-to-back commands.
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Drives one command and returns right after its transfer, at the next falling
  // edge. start stays high across back-to-back transfers and is only lowered when
  // a gap follows, so it never sees two assignments in one time step.
  task automatic issue(input logic act, input logic [gha_pkg::HANDLE_W-1:0] h);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    handle_in <= h;
    do @(posedge clk); while (busy !== 1'b0);
    last_result = ledger.note_command(act, h);
    if (act == gha_pkg::ACT_CREATE && last_result.status == gha_pkg::ST_OK)
      live_handles.push_back(last_result.handle);
    @(negedge clk);
  endtask

  // Creates carry random handle bits, since the block must ignore them.
  task automatic create_any();
    logic [gha_pkg::HANDLE_W-1:0] h;
    h = gha_pkg::HANDLE_W'($urandom);
    issue(gha_pkg::ACT_CREATE, h);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (ledger.due_results.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed traffic: creates and destroys of handles known to be live.
  // The rest replays stale handles, bumps a stale handle's generation so that it
  // may match an index waiting on the free stack, or sends arbitrary handles.
  task automatic random_item();
    int                           pick;
    int                           k;
    logic [gha_pkg::HANDLE_W-1:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 40 || (pick < 70 && live_handles.size() == 0)) begin
      create_any();
    end else if (pick < 70) begin
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      live_handles.delete(k);
      stale_handles.push_back(h);
      if (stale_handles.size() > 64) stale_handles.delete(0);
      issue(gha_pkg::ACT_DESTROY, h);
    end else if (pick < 84 && stale_handles.size() != 0) begin
      k = $urandom_range(0, stale_handles.size() - 1);
      h = stale_handles[k];
      if (pick >= 78) h[IDX_W +: GEN_W] = h[IDX_W +: GEN_W] + 1'b1;
      issue(gha_pkg::ACT_DESTROY, h);
    end else if (pick < 92) begin
      h = gha_pkg::HANDLE_W'($urandom);
      issue(gha_pkg::ACT_DESTROY, h);
    end else begin
      h = gha_pkg::HANDLE_W'($urandom);
      h[IDX_W-1:0] = IDX_W'($urandom_range(0, 16));
      issue(gha_pkg::ACT_DESTROY, h);
    end
  endtask

  initial begin
    logic [gha_pkg::HANDLE_W-1:0] base;
    rst       = 1'b1;
    start     = 1'b0;
    action    = gha_pkg::ACT_CREATE;
    handle_in = '0;
    calm_left = 0;
    ledger    = new();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: reserved index, indexes not yet issued, generation
    // mismatch, reuse in last-freed order, and a handle that is live again only
    // because its index sits on the free stack with a matching generation.
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, 0));
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, 1));
    create_any();
    create_any();
    issue(gha_pkg::ACT_DESTROY, pack_handle(1, 1));
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, 1));
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, 1));
    issue(gha_pkg::ACT_DESTROY, pack_handle(1, 1));
    create_any();
    create_any();
    create_any();
    issue(gha_pkg::ACT_DESTROY, {gha_pkg::HANDLE_W{1'b1}});
    issue(gha_pkg::ACT_DESTROY, pack_handle((1 << GEN_W) - 1, 2));
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, 2));
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, 3));
    create_any();
    create_any();
    create_any();
    issue(gha_pkg::ACT_DESTROY, pack_handle(2, 1));
    issue(gha_pkg::ACT_DESTROY, pack_handle(0, SLOTS - 1));

    repeat (550) random_item();

    // Hold the sender off until the block has delivered everything owed.
    wait_all_results();

    // Walk one index through every generation, so the generation wraps and
    // every generation bit of handle_out toggles: destroy pushes the index and
    // the following create pops it straight back.
    live_handles.delete();
    stale_handles.delete();
    create_any();
    base = last_result.handle;
    repeat (1 << GEN_W) begin
      issue(gha_pkg::ACT_DESTROY, base);
      create_any();
      base = last_result.handle;
    end
    live_handles.delete();
    live_handles.push_back(base);

    issue(gha_pkg::ACT_DESTROY, pack_handle(0, SLOTS - 1));
    repeat (150) random_item();

    wait_all_results();
    repeat (8) @(negedge clk);
    if (ledger.fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
